### rtl/core/gdac_pkg.sv
// ----------------------------------------------------------------------------
// gdac_pkg
// Shared types and constants of the GTP-U DNS allow-list classifier.
// ----------------------------------------------------------------------------
package gdac_pkg;

    // Fixed packet layout
    localparam logic [6:0] POS_MAX      = 7'd127;
    localparam logic [6:0] POS_LAST_MIN = 7'd87;   // last byte of a minimum-length candidate
    localparam logic [7:0] PROTO_UDP    = 8'd17;

    // Register reset values and indices
    localparam logic [15:0] TUNNEL_PORT_RST = 16'd2152;
    localparam logic [15:0] DNS_PORT_RST    = 16'd53;
    localparam logic [7:0]  CFG_TUNNEL_PORT = 8'd0;
    localparam logic [7:0]  CFG_DNS_PORT    = 8'd1;

    // Item commands
    localparam logic CMD_BYTE   = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_GATHER,
        S_APPLY
    } state_t;

    // Operation broadcast along the cell row
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOOK,
        OP_TOUCH,
        OP_REMOVE,
        OP_INSERT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic wr_txid;   // touch also rewrites the expected txid
        logic inc_all;   // insert: every other valid entry ages
    } cell_cmd_t;

endpackage

### rtl/core/gtpu_dns_allowlist_classifier_core.sv
// ----------------------------------------------------------------------------
// gtpu_dns_allowlist_classifier_core
// GTP-U encapsulated DNS query classifier with a consumable allow table.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low: command 0 carries one packet
//   byte (last_byte marks the end), command 1 inserts an allow entry.
//   Packet bytes that are not last give no result.
//   A last byte of a non-candidate packet gives its pass result in the
//   next cycle and the block stays free.
//   A DNS candidate and an insert each hold busy through the look, gather
//   and apply states: the table row compares its keys, the hit rank is
//   gathered, then ranks are updated; a candidate's result appears in the
//   cycle after the update.
//   So bytes run at one per cycle while busy is low, and each candidate
//   or insert holds off new items until the row's compare/gather/update pass ends.
//   result_valid marks each result for exactly one cycle; the receiver
//   cannot stall it. The user writes registers over cfg_valid/cfg_ready only
//   while idle; the block does not enforce it. cfg_ready is always high and
//   unknown indices are ignored. Reset empties the table, clears the parse
//   state and loads the default tunnel and DNS ports; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gtpu_dns_allowlist_classifier_core
    import gdac_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int QUEUE_COUNT   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  rx_queue,
    input  logic [31:0] key_src_ip,
    input  logic [31:0] key_dst_ip,
    input  logic [15:0] key_src_port,
    input  logic [15:0] key_dst_port,
    input  logic [15:0] key_txid,
    output logic        result_valid,
    output logic        verdict,
    output logic [5:0]  out_queue,
    output logic        entry_consumed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int N  = TABLE_ENTRIES;
    localparam int AW = (N > 1) ? $clog2(N) : 1;
    localparam logic [AW-1:0] AGE_OLDEST = AW'(N - 1);

    state_t state_reg, state_next;

    logic [15:0] tunnel_port_reg, dns_port_reg;
    logic        accept, byte_en, is_insert_reg;
    logic        cand;
    logic [31:0] p_src, p_dst;
    logic [15:0] p_sp, p_dp, p_tx;

    logic [63:0] key_tuple_reg;
    logic [31:0] key_ports_reg;
    logic [15:0] key_txid_reg;
    logic [5:0]  queue_reg;

    logic [N-1:0]  valid_vec, hit_vec, eq_vec, lru_vec, sel_vec;
    logic [N-1:0]  free_vec, low_free;
    logic [AW-1:0] age_arr [N];
    logic [AW-1:0] gather_age;
    logic [AW-1:0] old_age_reg, old_age;
    logic          any_hit_reg, hit_eq_reg, any_free_reg;
    cell_cmd_t     cmd;

    logic        res_valid_reg, verdict_reg, consumed_reg;
    logic [5:0]  oq_reg;
    logic        q_ok;

    assign accept    = start && !busy;
    assign byte_en   = accept && (command == CMD_BYTE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign q_ok      = ({3'b000, queue_reg} < 9'(QUEUE_COUNT));

    // Header parser
    gdac_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (byte_en),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .tunnel_port (tunnel_port_reg),
        .dns_port    (dns_port_reg),
        .candidate   (cand),
        .src_addr    (p_src),
        .dst_addr    (p_dst),
        .inner_sport (p_sp),
        .dst_port    (p_dp),
        .txid        (p_tx)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tunnel_port_reg <= TUNNEL_PORT_RST;
            dns_port_reg    <= DNS_PORT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_TUNNEL_PORT)
                tunnel_port_reg <= cfg_data;
            else if (cfg_index == CFG_DNS_PORT)
                dns_port_reg <= cfg_data;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && (command == CMD_INSERT || (last_byte && cand)))
                    state_next = S_LOOK;
            S_LOOK:   state_next = S_GATHER;
            S_GATHER: state_next = S_APPLY;
            S_APPLY:  state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Key latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (command == CMD_INSERT)
            begin
                key_tuple_reg <= {key_src_ip, key_dst_ip};
                key_ports_reg <= {key_src_port, key_dst_port};
                key_txid_reg  <= key_txid;
            end
            else if (last_byte)
            begin
                key_tuple_reg <= {p_src, p_dst};
                key_ports_reg <= {p_sp, p_dp};
                key_txid_reg  <= p_tx;
            end
            queue_reg <= rx_queue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            is_insert_reg <= 1'b0;
        else if (accept)
            is_insert_reg <= (command == CMD_INSERT);
    end

    // Gather rank of the hit entry and table summary
    always_comb
    begin
        gather_age = '0;
        for (int i = 0; i < N; i++)
            gather_age = gather_age | (hit_vec[i] ? age_arr[i] : '0);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_GATHER)
        begin
            old_age_reg  <= gather_age;
            any_hit_reg  <= |hit_vec;
            hit_eq_reg   <= |(hit_vec & eq_vec);
            any_free_reg <= |free_vec;
        end
    end

    assign free_vec = ~valid_vec;
    assign low_free = free_vec & (~free_vec + 1'b1);

    // Row command outputs
    always_comb
    begin
        cmd     = '{op: OP_NONE, wr_txid: 1'b0, inc_all: 1'b0};
        sel_vec = '0;
        old_age = old_age_reg;
        case (state_reg)
            S_LOOK: cmd.op = OP_LOOK;
            S_APPLY:
            begin
                if (is_insert_reg)
                begin
                    if (any_hit_reg)
                    begin
                        cmd.op      = OP_TOUCH;
                        cmd.wr_txid = 1'b1;
                        sel_vec     = hit_vec;
                    end
                    else if (any_free_reg)
                    begin
                        cmd.op      = OP_INSERT;
                        cmd.inc_all = 1'b1;
                        sel_vec     = low_free;
                    end
                    else
                    begin
                        cmd.op  = OP_INSERT;
                        sel_vec = lru_vec;
                        old_age = AGE_OLDEST;
                    end
                end
                else if (any_hit_reg)
                begin
                    cmd.op  = hit_eq_reg ? OP_REMOVE : OP_TOUCH;
                    sel_vec = hit_vec;
                end
            end
            default: ;
        endcase
    end

    // Table row
    for (genvar g = 0; g < N; g++)
    begin : g_cell
        gdac_cell #(.AW(AW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .sel       (sel_vec[g]),
            .old_age   (old_age),
            .key_tuple (key_tuple_reg),
            .key_ports (key_ports_reg),
            .key_txid  (key_txid_reg),
            .valid     (valid_vec[g]),
            .hit       (hit_vec[g]),
            .txid_eq   (eq_vec[g]),
            .age       (age_arr[g])
        );
        assign lru_vec[g] = valid_vec[g] && (age_arr[g] == AGE_OLDEST);
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            verdict_reg   <= 1'b0;
            oq_reg        <= '0;
            consumed_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= 1'b0;
            if (byte_en && last_byte && !cand)
            begin
                res_valid_reg <= 1'b1;
                verdict_reg   <= 1'b0;
                oq_reg        <= '0;
                consumed_reg  <= 1'b0;
            end
            else if (state_reg == S_APPLY && !is_insert_reg)
            begin
                res_valid_reg <= 1'b1;
                if (any_hit_reg && hit_eq_reg)
                begin
                    verdict_reg  <= 1'b0;
                    oq_reg       <= '0;
                    consumed_reg <= 1'b1;
                end
                else
                begin
                    verdict_reg  <= q_ok;
                    oq_reg       <= q_ok ? queue_reg : 6'd0;
                    consumed_reg <= 1'b0;
                end
            end
        end
    end

    assign result_valid   = res_valid_reg;
    assign verdict        = verdict_reg;
    assign out_queue      = oq_reg;
    assign entry_consumed = consumed_reg;

    // Checks
    a_apply_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle after update");

    a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_APPLY |-> $onehot0(sel_vec))
        else $error("more than one table entry selected");

    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_GATHER |-> $onehot0(hit_vec))
        else $error("tuple held in more than one entry");

    a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(verdict && entry_consumed) && (verdict || out_queue == 6'd0))
        else $error("inconsistent result item");

endmodule

### rtl/core/gdac_parser.sv
// ----------------------------------------------------------------------------
// gdac_parser
// Fixed-offset header parser: tracks byte position and captures the inner
// four-tuple and DNS transaction id, flagging DNS candidates on the last byte.
// ----------------------------------------------------------------------------
module gdac_parser
    import gdac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_en,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [15:0] tunnel_port,
    input  logic [15:0] dns_port,
    output logic        candidate,
    output logic [31:0] src_addr,
    output logic [31:0] dst_addr,
    output logic [15:0] inner_sport,
    output logic [15:0] dst_port,
    output logic [15:0] txid
);

    logic [6:0]  pos_reg,   pos_next;
    logic        match_reg, match_next;
    logic [7:0]  proto_reg, proto_next;
    logic [31:0] src_reg,   src_next;
    logic [31:0] dst_reg,   dst_next;
    logic [15:0] sp_reg,    sp_next;
    logic [15:0] dp_reg,    dp_next;
    logic [15:0] tx_reg,    tx_next;

    // Capture at fixed offsets
    always_comb
    begin
        match_next = match_reg;
        proto_next = proto_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        sp_next    = sp_reg;
        dp_next    = dp_reg;
        tx_next    = tx_reg;
        case (pos_reg)
            7'd34: match_next = (data_byte == tunnel_port[15:8]);
            7'd35, 7'd37: match_next = match_reg && (data_byte == tunnel_port[7:0]);
            7'd36: match_next = match_reg && (data_byte == tunnel_port[15:8]);
            7'd67: proto_next = data_byte;
            7'd70, 7'd71, 7'd72, 7'd73: src_next = {src_reg[23:0], data_byte};
            7'd74, 7'd75, 7'd76, 7'd77: dst_next = {dst_reg[23:0], data_byte};
            7'd78, 7'd79: sp_next = {sp_reg[7:0], data_byte};
            7'd80, 7'd81: dp_next = {dp_reg[7:0], data_byte};
            7'd86, 7'd87: tx_next = {tx_reg[7:0], data_byte};
            default: ;
        endcase
        pos_next = (pos_reg < POS_MAX) ? pos_reg + 7'd1 : pos_reg;
    end

    assign candidate = (pos_reg >= POS_LAST_MIN) && match_next && (proto_next == PROTO_UDP)
                       && (dp_next == dns_port);
    assign src_addr    = src_next;
    assign dst_addr    = dst_next;
    assign inner_sport = sp_next;
    assign dst_port    = dp_next;
    assign txid        = tx_next;

    // Parse state; cleared at packet end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            match_reg <= 1'b0;
            proto_reg <= '0;
            src_reg   <= '0;
            dst_reg   <= '0;
            sp_reg    <= '0;
            dp_reg    <= '0;
            tx_reg    <= '0;
        end
        else if (byte_en)
        begin
            if (last_byte)
            begin
                pos_reg   <= '0;
                match_reg <= 1'b0;
                proto_reg <= '0;
                src_reg   <= '0;
                dst_reg   <= '0;
                sp_reg    <= '0;
                dp_reg    <= '0;
                tx_reg    <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                match_reg <= match_next;
                proto_reg <= proto_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                sp_reg    <= sp_next;
                dp_reg    <= dp_next;
                tx_reg    <= tx_next;
            end
        end
    end

endmodule

### rtl/core/gdac_cell.sv
// ----------------------------------------------------------------------------
// gdac_cell
// One allow-table entry: key, expected txid, valid flag and LRU rank.
// Compares itself against the broadcast key and applies rank updates.
// ----------------------------------------------------------------------------
module gdac_cell
    import gdac_pkg::*;
#(
    parameter int AW = 6
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cell_cmd_t     cmd,
    input  logic          sel,
    input  logic [AW-1:0] old_age,
    input  logic [63:0]   key_tuple,
    input  logic [31:0]   key_ports,
    input  logic [15:0]   key_txid,
    output logic          valid,
    output logic          hit,
    output logic          txid_eq,
    output logic [AW-1:0] age
);

    logic          valid_reg, valid_next;
    logic [AW-1:0] age_reg,   age_next;
    logic          hit_reg,   eq_reg;
    logic [63:0]   tuple_reg;
    logic [31:0]   ports_reg;
    logic [15:0]   txid_reg;

    // Rank and valid update
    always_comb
    begin
        valid_next = valid_reg;
        age_next   = age_reg;
        case (cmd.op)
            OP_TOUCH:
            begin
                if (sel)
                    age_next = '0;
                else if (valid_reg && age_reg < old_age)
                    age_next = age_reg + 1'b1;
            end
            OP_REMOVE:
            begin
                if (sel)
                begin
                    valid_next = 1'b0;
                    age_next   = '0;
                end
                else if (valid_reg && age_reg > old_age)
                    age_next = age_reg - 1'b1;
            end
            OP_INSERT:
            begin
                if (sel)
                begin
                    valid_next = 1'b1;
                    age_next   = '0;
                end
                else if (valid_reg && (cmd.inc_all || age_reg < old_age))
                    age_next = age_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            hit_reg   <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            if (cmd.op == OP_LOOK)
            begin
                hit_reg <= valid_reg && (tuple_reg == key_tuple) && (ports_reg == key_ports);
                eq_reg  <= (txid_reg == key_txid);
            end
        end
    end

    // Entry payload
    always_ff @(posedge clk)
    begin
        if (sel && cmd.op == OP_INSERT)
        begin
            tuple_reg <= key_tuple;
            ports_reg <= key_ports;
        end
        if (sel && (cmd.op == OP_INSERT || (cmd.op == OP_TOUCH && cmd.wr_txid)))
            txid_reg <= key_txid;
    end

    assign valid   = valid_reg;
    assign hit     = hit_reg;
    assign txid_eq = eq_reg;
    assign age     = age_reg;

endmodule

### test/gdac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdac_checker
// Watches the item, result and register channels of the classifier, keeps its
// own copy of the parse state and the allow table, predicts each verdict and
// compares it field by field with what the block gives.
// ----------------------------------------------------------------------------
module gdac_checker
    import gdac_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64,
    parameter int QUEUE_COUNT   = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [5:0]  rx_queue,
    input  logic [31:0] key_src_ip,
    input  logic [31:0] key_dst_ip,
    input  logic [15:0] key_src_port,
    input  logic [15:0] key_dst_port,
    input  logic [15:0] key_txid,
    input  logic        result_valid,
    input  logic        verdict,
    input  logic [5:0]  out_queue,
    input  logic        entry_consumed,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          consumed_count,
    output int          redirect_count
);

    typedef struct packed {
        logic       verdict;
        logic [5:0] queue;
        logic       consumed;
    } verdict_t;

    verdict_t verdict_q[$];

    // Shadow registers and parse state
    logic [15:0] tun_port;
    logic [15:0] dns_port;
    int          pos;
    bit          ports_ok;
    logic [7:0]  proto;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] in_sport;
    logic [15:0] dst_port;
    logic [15:0] txid;

    // Shadow allow table
    bit          tbl_valid [TABLE_ENTRIES];
    logic [63:0] tbl_tuple [TABLE_ENTRIES];
    logic [31:0] tbl_ports [TABLE_ENTRIES];
    logic [15:0] tbl_txid  [TABLE_ENTRIES];
    int          tbl_age   [TABLE_ENTRIES];

    assign pending = verdict_q.size();

    task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        fail_count++;
    endtask

    function automatic int lookup(input logic [63:0] tup, input logic [31:0] prt);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_tuple[i] == tup && tbl_ports[i] == prt)
                return i;
        return -1;
    endfunction

    task automatic touch(input int k);
        int old;
        old = tbl_age[k];
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && i != k && tbl_age[i] < old)
                tbl_age[i]++;
        tbl_age[k] = 0;
    endtask

    task automatic evict(input int k);
        int old;
        old = tbl_age[k];
        tbl_valid[k] = 0;
        tbl_age[k] = 0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (tbl_valid[i] && tbl_age[i] > old)
                tbl_age[i]--;
    endtask

    task automatic add_entry(input logic [63:0] tup, input logic [31:0] prt,
                             input logic [15:0] id);
        int k;
        int n;
        k = lookup(tup, prt);
        if (k < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (!tbl_valid[i] && k < 0)
                    k = i;
            if (k < 0) begin
                // full: replace the oldest
                k = 0;
                for (int i = 1; i < TABLE_ENTRIES; i++)
                    if (tbl_age[i] > tbl_age[k])
                        k = i;
            end
            else begin
                n = 0;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                    if (tbl_valid[i])
                        n++;
                tbl_valid[k] = 1;
                tbl_age[k] = n;
            end
            tbl_tuple[k] = tup;
            tbl_ports[k] = prt;
        end
        tbl_txid[k] = id;
        touch(k);
    endtask

    task automatic clear_parse();
        pos = 0;
        ports_ok = 0;
        proto = '0;
        src_addr = '0;
        dst_addr = '0;
        in_sport = '0;
        dst_port = '0;
        txid = '0;
    endtask

    // Works out the verdict of one accepted item, if it gives one
    task automatic classify(output bit has_res, output verdict_t res);
        logic [7:0] b;
        int k;
        b = data_byte;
        has_res = 0;
        res = '0;
        if (command != CMD_BYTE) begin
            add_entry({key_src_ip, key_dst_ip}, {key_src_port, key_dst_port}, key_txid);
            return;
        end
        case (pos)
            34: ports_ok = (b == tun_port[15:8]);
            35, 37: ports_ok = ports_ok && (b == tun_port[7:0]);
            36: ports_ok = ports_ok && (b == tun_port[15:8]);
            67: proto = b;
            70, 71, 72, 73: src_addr = {src_addr[23:0], b};
            74, 75, 76, 77: dst_addr = {dst_addr[23:0], b};
            78, 79: in_sport = {in_sport[7:0], b};
            80, 81: dst_port = {dst_port[7:0], b};
            86, 87: txid = {txid[7:0], b};
            default: ;
        endcase
        if (!last_byte) begin
            if (pos < POS_MAX)
                pos++;
            return;
        end
        has_res = 1;
        if (pos >= POS_LAST_MIN && ports_ok && proto == PROTO_UDP && dst_port == dns_port) begin
            k = lookup({src_addr, dst_addr}, {in_sport, dst_port});
            if (k >= 0 && tbl_txid[k] == txid) begin
                evict(k);
                res.consumed = 1;
            end
            else begin
                if (k >= 0)
                    touch(k);
                if (rx_queue < QUEUE_COUNT) begin
                    res.verdict = 1;
                    res.queue = rx_queue;
                end
            end
        end
        clear_parse();
    endtask

    initial
    begin
        fail_count = 0;
        consumed_count = 0;
        redirect_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        bit       has_res;
        verdict_t res;
        verdict_t want;
        if (!rst_n) begin
            tun_port = TUNNEL_PORT_RST;
            dns_port = DNS_PORT_RST;
            clear_parse();
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tbl_valid[i] = 0;
                tbl_age[i] = 0;
                tbl_tuple[i] = '0;
                tbl_ports[i] = '0;
                tbl_txid[i] = '0;
            end
            verdict_q.delete();
        end
        else begin
            // results belong to items taken at earlier edges
            if (result_valid) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t unexpected result", $time);
                    fail_count++;
                end
                else begin
                    want = verdict_q.pop_front();
                    if (verdict !== want.verdict)
                        report("verdict", 8'(verdict), 8'(want.verdict));
                    if (out_queue !== want.queue)
                        report("out_queue", 8'(out_queue), 8'(want.queue));
                    if (entry_consumed !== want.consumed)
                        report("entry_consumed", 8'(entry_consumed), 8'(want.consumed));
                    if (want.consumed)
                        consumed_count++;
                    if (want.verdict)
                        redirect_count++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_TUNNEL_PORT)
                    tun_port = cfg_data;
                else if (cfg_index == CFG_DNS_PORT)
                    dns_port = cfg_data;
            end
            if (start && !busy) begin
                classify(has_res, res);
                if (has_res)
                    verdict_q.push_back(res);
            end
        end
    end

endmodule

### test/tb_gtpu_dns_allowlist_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gtpu_dns_allowlist_classifier_core
// Drives tunnelled DNS packets and allow-table inserts into the classifier
// in bursts, across several tunnel and DNS port settings; the checker
// predicts every verdict and counts mismatches.
// ----------------------------------------------------------------------------
module tb_gtpu_dns_allowlist_classifier_core
    import gdac_pkg::*;
;

    localparam int POOL     = 96;
    localparam int WD_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [5:0]  rx_queue;
    logic [31:0] key_src_ip;
    logic [31:0] key_dst_ip;
    logic [15:0] key_src_port;
    logic [15:0] key_dst_port;
    logic [15:0] key_txid;
    logic        result_valid;
    logic        verdict;
    logic [5:0]  out_queue;
    logic        entry_consumed;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int consumed_count;
    int redirect_count;

    // Flow pool shared by inserts and packets
    logic [31:0] pool_src  [POOL];
    logic [31:0] pool_dst  [POOL];
    logic [15:0] pool_sprt [POOL];

    logic [15:0] cur_tun;
    logic [15:0] cur_dns;
    logic [7:0]  pkt [160];
    int          burst_left;
    int          item_count;
    int          result_count;
    int          idle_cycles;
    int          settings_count;

    gtpu_dns_allowlist_classifier_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .data_byte(data_byte), .last_byte(last_byte),
        .rx_queue(rx_queue), .key_src_ip(key_src_ip), .key_dst_ip(key_dst_ip),
        .key_src_port(key_src_port), .key_dst_port(key_dst_port), .key_txid(key_txid),
        .result_valid(result_valid), .verdict(verdict), .out_queue(out_queue),
        .entry_consumed(entry_consumed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    gdac_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .data_byte(data_byte), .last_byte(last_byte),
        .rx_queue(rx_queue), .key_src_ip(key_src_ip), .key_dst_ip(key_dst_ip),
        .key_src_port(key_src_port), .key_dst_port(key_dst_port), .key_txid(key_txid),
        .result_valid(result_valid), .verdict(verdict), .out_queue(out_queue),
        .entry_consumed(entry_consumed), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .consumed_count(consumed_count), .redirect_count(redirect_count)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (result_valid)
            result_count++;
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("[gtpu_dns_allowlist_classifier_core] ERROR");
            $finish;
        end
    end

    // One item; stays raised across a burst, gaps between bursts
    task automatic send_item(input logic cmd, input logic [7:0] b, input logic lst,
                             input logic [5:0] q, input logic [31:0] sa,
                             input logic [31:0] da, input logic [15:0] sp,
                             input logic [15:0] dp, input logic [15:0] id);
        start        <= 1'b1;
        command      <= cmd;
        data_byte    <= b;
        last_byte    <= lst;
        rx_queue     <= q;
        key_src_ip   <= sa;
        key_dst_ip   <= da;
        key_src_port <= sp;
        key_dst_port <= dp;
        key_txid     <= id;
        do
            @(posedge clk);
        while (busy);
        item_count++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
        end
    endtask

    task automatic insert_flow(input int f, input logic [15:0] id);
        send_item(CMD_INSERT, 8'($urandom), 1'($urandom), 6'($urandom), pool_src[f],
                  pool_dst[f], pool_sprt[f], cur_dns, id);
    endtask

    // Builds a packet around flow f; broken selects which field is spoiled
    task automatic send_packet(input int len, input int f, input logic [15:0] id,
                               input int broken, input bit mid_insert);
        for (int i = 0; i < 160; i++)
            pkt[i] = 8'($urandom);
        pkt[34] = cur_tun[15:8];
        pkt[35] = cur_tun[7:0];
        pkt[36] = cur_tun[15:8];
        pkt[37] = cur_tun[7:0];
        pkt[67] = PROTO_UDP;
        {pkt[70], pkt[71], pkt[72], pkt[73]} = pool_src[f];
        {pkt[74], pkt[75], pkt[76], pkt[77]} = pool_dst[f];
        {pkt[78], pkt[79]} = pool_sprt[f];
        {pkt[80], pkt[81]} = cur_dns;
        {pkt[86], pkt[87]} = id;
        case (broken)
            1: pkt[$urandom_range(34, 37)] ^= 8'h01 << $urandom_range(0, 7);
            2: pkt[67] = $urandom_range(0, 1) ? 8'd6 : 8'd255;
            3: pkt[$urandom_range(80, 81)] ^= 8'h80;
            4: pkt[$urandom_range(70, 79)] ^= 8'h01 << $urandom_range(0, 7);
            default: ;
        endcase
        for (int i = 0; i < len; i++) begin
            if (mid_insert && $urandom_range(0, 63) == 0)
                insert_flow($urandom_range(0, POOL - 1), 16'($urandom_range(0, 3)));
            send_item(CMD_BYTE, pkt[i], i == len - 1, 6'($urandom), $urandom, $urandom,
                      16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // Waits for every verdict and the block's pass to settle
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TUNNEL_PORT)
            cur_tun = val;
        else if (idx == CFG_DNS_PORT)
            cur_dns = val;
    endtask

    task automatic set_ports(input logic [15:0] tun, input logic [15:0] dns);
        write_reg(CFG_TUNNEL_PORT, tun);
        write_reg(CFG_DNS_PORT, dns);
        // unknown index, must change nothing
        write_reg(8'($urandom_range(2, 255)), 16'($urandom));
        settings_count++;
    endtask

    task automatic random_phase(input int items);
        int stop_at;
        int f;
        int len;
        int pick;
        stop_at = item_count + items;
        while (item_count < stop_at) begin
            pick = $urandom_range(0, 99);
            f = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 11) : $urandom_range(0, POOL - 1);
            if (pick < 30)
                insert_flow(f, 16'($urandom_range(0, 3)));
            else begin
                len = 88;
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(1, 12);
                    1: len = 87;
                    2: len = $urandom_range(89, 127);
                    3: len = $urandom_range(128, 150);
                    default: ;
                endcase
                send_packet(len, f, 16'($urandom_range(0, 3)),
                            ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0,
                            $urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_BYTE;
        data_byte = '0;
        last_byte = 1'b0;
        rx_queue = '0;
        key_src_ip = '0;
        key_dst_ip = '0;
        key_src_port = '0;
        key_dst_port = '0;
        key_txid = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cur_tun = TUNNEL_PORT_RST;
        cur_dns = DNS_PORT_RST;
        burst_left = 10;
        item_count = 0;
        result_count = 0;
        idle_cycles = 0;
        settings_count = 1;
        for (int i = 0; i < POOL; i++) begin
            pool_src[i] = $urandom;
            pool_dst[i] = $urandom;
            pool_sprt[i] = 16'($urandom);
        end
        pool_src[0] = '1;
        pool_dst[0] = '1;
        pool_sprt[0] = '1;
        pool_src[1] = '0;
        pool_dst[1] = '0;
        pool_sprt[1] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: consume, txid mismatch, re-insert, short and long packets
        insert_flow(0, 16'hFFFF);
        send_packet(88, 0, 16'hFFFF, 0, 0);
        send_packet(88, 0, 16'hFFFF, 0, 0);
        insert_flow(1, 16'h0000);
        send_packet(88, 1, 16'h0001, 0, 0);
        insert_flow(1, 16'h0001);
        send_packet(88, 1, 16'h0001, 0, 0);
        send_packet(1, 2, 0, 0, 0);
        send_packet(87, 2, 0, 0, 0);
        send_packet(140, 2, 0, 0, 0);
        // fill beyond capacity to force replacement
        for (int i = 0; i < 70; i++)
            insert_flow(i + 2, 16'h0000);
        send_packet(88, 2, 0, 0, 0);
        send_packet(88, 71, 0, 0, 0);
        drain();

        random_phase(400);
        drain();
        set_ports(16'h0000, 16'h0000);
        random_phase(300);
        drain();
        set_ports(16'hFFFF, 16'hFFFF);
        random_phase(300);
        drain();
        set_ports(16'($urandom), 16'($urandom));
        random_phase(300);
        drain();

        $display("items %0d, verdicts %0d (%0d redirects, %0d entries consumed)",
                 item_count, result_count, redirect_count, consumed_count);
        $display("port settings exercised: %0d", settings_count);
        if (fail_count == 0)
            $display("[gtpu_dns_allowlist_classifier_core] OK");
        else
            $display("[gtpu_dns_allowlist_classifier_core] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/core/gdac_pkg.sv
rtl/core/gdac_parser.sv
rtl/core/gdac_cell.sv
rtl/core/gtpu_dns_allowlist_classifier_core.sv
test/gdac_checker.sv
test/tb_gtpu_dns_allowlist_classifier_core.sv
